// ===== sv/node_renumber_by_coordinate_rank_core_assert.svh =====
// Assertion macros used by the checker module of the renumbering core.
// Each macro names a clock of clk and a synchronous active-low reset of rst_n
// in the scope where it is used.
`ifndef NODE_RENUMBER_BY_COORDINATE_RANK_CORE_ASSERT_SVH
`define NODE_RENUMBER_BY_COORDINATE_RANK_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NRCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("renumbering core check failed");

// The consequent must hold in the cycle after the antecedent.
`define NRCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("renumbering core check failed");

`endif

// ===== sv/nrcr_pkg.sv =====
// ----------------------------------------------------------------------------
// nrcr_pkg
// Types and fixed constants for the node renumbering core: the input and
// result word layouts, operation codes, order modes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package nrcr_pkg;

  // Fixed field widths.
  localparam int COORD_BITS = 32;
  localparam int IDX_BITS   = 10;
  localparam int MODE_BITS  = 2;

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Order modes; the unused code behaves like MODE_KEEP.
  localparam logic [MODE_BITS-1:0] MODE_KEEP = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_X    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_Y    = 2'd2;

  // Register index of order_mode (byte address 4 * index).
  localparam logic REG_ORDER_MODE = 1'b0;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Input word.
  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         last_node;
    logic [IDX_BITS-1:0]          node_index;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic [IDX_BITS-1:0] new_number;
    logic                status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/node_renumber_by_coordinate_rank_core.sv =====
// ----------------------------------------------------------------------------
// node_renumber_by_coordinate_rank_core
// Stores mesh node coordinates and answers renumbering reads by counting,
// one stored node per cycle, the nodes that rank ahead of the asked node.
// ----------------------------------------------------------------------------
// A load word leaves the core idle, so the core is ready again for the next
// word. A read in keep mode, or a read that fails, passes through the finish
// state into the output register. A read in x or y mode issues the key fetch,
// captures the key, scans (a fetch for each stored node, a last compare and a
// step to close the count) and then posts the result. The scan length comes
// from the single read port of the coordinate memory, which feeds one signed
// comparator with one stored node per cycle. The coordinate memory is not
// cleared after reset; only loaded nodes are ever read, so the core is ready
// straight out of reset. The core takes no new word while a read is in
// progress. A finished result waits in the output register while further
// load words are taken.
`default_nettype none

module node_renumber_by_coordinate_rank_core #(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire nrcr_pkg::in_item_t   in_data,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output nrcr_pkg::out_item_t       out_data,
  // Configuration port.
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int CB   = nrcr_pkg::COORD_BITS;
  localparam int IB   = nrcr_pkg::IDX_BITS;
  localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int CMPW = (CW > IB) ? CW : IB;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Control registers.
  logic [1:0]                     state_r, state_nxt;
  logic [nrcr_pkg::MODE_BITS-1:0] order_mode_r;
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           set_complete_r, set_complete_nxt;
  logic                           cmp_v_r, cmp_v_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // Payload registers.
  logic signed [CB-1:0]           key_r, key_nxt;
  logic [IB-1:0]                  idx_r, idx_nxt;
  logic                           use_y_r, use_y_nxt;
  logic [CW-1:0]                  scan_j_r, scan_j_nxt;
  logic [AW-1:0]                  cmp_j_r, cmp_j_nxt;
  logic [AW-1:0]                  rank_r, rank_nxt;
  logic [IB-1:0]                  res_num_r, res_num_nxt;
  logic                           res_status_r, res_status_nxt;
  nrcr_pkg::out_item_t            out_data_r, out_data_nxt;

  // Coordinate memory, {x, y} per node.
  logic [2*CB-1:0]                mem [MAX_NODES];
  logic [2*CB-1:0]                rd_data_r;
  logic                           mem_we, mem_re;
  logic [AW-1:0]                  mem_waddr, mem_raddr;

  logic                           accept, is_load, is_read, read_err, sort_mode;
  logic                           issue, ahead, out_free;
  logic [CW-1:0]                  load_slot;
  logic signed [CB-1:0]           scan_data;
  logic                           cfg_write;

  // Configuration port: always ready, one register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == nrcr_pkg::REG_ORDER_MODE);
  assign prdata    = (paddr[2] == nrcr_pkg::REG_ORDER_MODE) ? 32'(order_mode_r) : '0;

  // Handshake decode.
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_load   = accept && (in_data.op == nrcr_pkg::OP_LOAD);
  assign is_read   = accept && (in_data.op == nrcr_pkg::OP_READ);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // A load after a complete set starts a new set at slot zero.
  assign load_slot = set_complete_r ? '0 : count_r;
  assign mem_we    = is_load && (load_slot < CW'(MAX_NODES));
  assign mem_waddr = load_slot[AW-1:0];

  assign read_err  = !set_complete_r || (CMPW'(in_data.node_index) >= CMPW'(count_r));
  assign sort_mode = (order_mode_r == nrcr_pkg::MODE_X) || (order_mode_r == nrcr_pkg::MODE_Y);

  // Memory read address: the asked node at accept, then the scan index.
  assign issue     = (state_r == ST_SCAN) && (scan_j_r < count_r);
  assign mem_re    = is_read || issue;
  assign mem_raddr = (state_r == ST_SCAN) ? scan_j_r[AW-1:0] : AW'(in_data.node_index);

  // Shared comparator: does the scanned node rank ahead of the asked node?
  assign scan_data = use_y_r ? $signed(rd_data_r[CB-1:0]) : $signed(rd_data_r[2*CB-1:CB]);
  assign ahead     = (scan_data > key_r) ||
                     ((scan_data == key_r) && (CMPW'(cmp_j_r) < CMPW'(idx_r)));

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    set_complete_nxt = set_complete_r;
    cmp_v_nxt        = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ready;
    key_nxt          = key_r;
    idx_nxt          = idx_r;
    use_y_nxt        = use_y_r;
    scan_j_nxt       = scan_j_r;
    cmp_j_nxt        = cmp_j_r;
    rank_nxt         = rank_r;
    res_num_nxt      = res_num_r;
    res_status_nxt   = res_status_r;
    out_data_nxt     = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (is_load) begin
          count_nxt        = mem_we ? (load_slot + 1'b1) : load_slot;
          set_complete_nxt = in_data.last_node;
        end
        if (is_read) begin
          idx_nxt   = in_data.node_index;
          use_y_nxt = (order_mode_r == nrcr_pkg::MODE_Y);
          rank_nxt  = '0;
          if (read_err) begin
            res_num_nxt    = '0;
            res_status_nxt = nrcr_pkg::STATUS_ERR;
            state_nxt      = ST_FIN;
          end else if (sort_mode) begin
            state_nxt = ST_KEY;
          end else begin
            res_num_nxt    = in_data.node_index;
            res_status_nxt = nrcr_pkg::STATUS_OK;
            state_nxt      = ST_FIN;
          end
        end
      end
      ST_KEY: begin
        key_nxt    = scan_data;
        scan_j_nxt = '0;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue) begin
          scan_j_nxt = scan_j_r + 1'b1;
          cmp_j_nxt  = scan_j_r[AW-1:0];
          cmp_v_nxt  = 1'b1;
        end
        if (cmp_v_r && ahead) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (!issue && !cmp_v_r) begin
          res_num_nxt    = IB'(rank_r);
          res_status_nxt = nrcr_pkg::STATUS_OK;
          state_nxt      = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_data_nxt.new_number = res_num_r;
          out_data_nxt.status     = res_status_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      order_mode_r   <= nrcr_pkg::MODE_KEEP;
      count_r        <= '0;
      set_complete_r <= 1'b0;
      cmp_v_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      set_complete_r <= set_complete_nxt;
      cmp_v_r        <= cmp_v_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_write) begin
        order_mode_r <= pwdata[nrcr_pkg::MODE_BITS-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    use_y_r      <= use_y_nxt;
    scan_j_r     <= scan_j_nxt;
    cmp_j_r      <= cmp_j_nxt;
    rank_r       <= rank_nxt;
    res_num_r    <= res_num_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Coordinate memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {in_data.coord_x, in_data.coord_y};
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/nrcr_checker.sv =====
// ----------------------------------------------------------------------------
// nrcr_checker
// Port-level checks for the node renumbering core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "node_renumber_by_coordinate_rank_core_assert.svh"

module nrcr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire nrcr_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire nrcr_pkg::out_item_t out_data
);

  logic out_err, rd_take, ld_take;

  // Accepted read and load words, and a presented failed result.
  assign out_err = out_valid && (out_data.status == nrcr_pkg::STATUS_ERR);
  assign rd_take = in_valid && in_ready && (in_data.op == nrcr_pkg::OP_READ);
  assign ld_take = in_valid && in_ready && (in_data.op == nrcr_pkg::OP_LOAD);

  // A stalled result word keeps its contents.
  `NRCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A failed read always reports node number zero.
  `NRCR_ASSERT_SAME(a_err_zero, out_err, out_data.new_number == '0)

  // A read word occupies the core for at least the following cycle.
  `NRCR_ASSERT_NEXT(a_read_busy, rd_take, !in_ready)

  // A load word leaves the core ready again in the following cycle.
  `NRCR_ASSERT_NEXT(a_load_ready, ld_take, in_ready)

endmodule

bind node_renumber_by_coordinate_rank_core nrcr_checker u_nrcr_checker (.*);

`default_nettype wire
